[rtl/unix_seconds_to_calendar_date_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the epoch-seconds to calendar-date converter
// Shared property wrappers, sampled on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef UNIX_SECONDS_TO_CALENDAR_DATE_TOP_DEFINES_SVH
`define UNIX_SECONDS_TO_CALENDAR_DATE_TOP_DEFINES_SVH

// Generic clocked property check.
`define USD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A stalled request keeps its payload.
`define USD_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> $stable(sig)) else $error(msg);

`endif

[rtl/usd_pkg.sv]
// ----------------------------------------------------------------------------
// usd_pkg
// Types and constants of the epoch-seconds to calendar-date converter.
// ----------------------------------------------------------------------------
package usd_pkg;

  localparam int unsigned PIPE_DEPTH = 8;

  typedef logic [31:0] epoch_t;
  typedef logic [15:0] days_t;
  typedef logic [5:0]  sec_t;
  typedef logic [5:0]  min_t;
  typedef logic [4:0]  hour_t;
  typedef logic [4:0]  mday_t;
  typedef logic [3:0]  month_t;
  typedef logic [7:0]  year_t;
  typedef logic [2:0]  wday_t;

  localparam int unsigned DAYS_W = 16;

  typedef struct packed {
    sec_t  sec;
    min_t  min;
    hour_t hour;
    wday_t wday;
  } tod_t;

  // calendar constants
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned DAYS_PER_WEEK = 7;
  localparam int unsigned EPOCH_JDN     = 2440588;
  localparam int unsigned JDN_SHIFT     = 32044;
  localparam int unsigned DAYS_PER_400Y = 146097;
  localparam int unsigned DAYS_PER_4Y   = 1461;
  localparam int unsigned MONTH_SPAN    = 153;
  localparam int unsigned YEAR_BASE     = 4800;
  localparam int unsigned EPOCH_YEAR    = 1970;
  localparam int unsigned YEARS_PER_CENT = 100;
  localparam int unsigned MONTH_WRAP    = 10;
  localparam int unsigned MONTH_FOLD    = 9;
  localparam int unsigned MONTH_START   = 3;

  localparam int unsigned JDN_BASE     = EPOCH_JDN + JDN_SHIFT;
  localparam int unsigned WEEKDAY_BIAS = EPOCH_JDN % DAYS_PER_WEEK;
  localparam int unsigned YEAR_BIAS    = YEAR_BASE + EPOCH_YEAR;

  // reciprocal multipliers: floor(x / div) == (x * recip) >> shift, exact
  // for every x of the stated width
  localparam int unsigned DAY_PRE   = 7;
  localparam int unsigned DAY_DIV   = SECS_PER_DAY >> DAY_PRE;
  localparam int unsigned DAY_SHIFT = 35;
  localparam longint unsigned DAY_RECIP =
    ((64'd1 << DAY_SHIFT) + 64'(DAY_DIV) - 64'd1) / 64'(DAY_DIV);

  localparam int unsigned HOUR_PRE   = 4;
  localparam int unsigned HOUR_DIV   = SECS_PER_HOUR >> HOUR_PRE;
  localparam int unsigned HOUR_SHIFT = 21;
  localparam longint unsigned HOUR_RECIP =
    ((64'd1 << HOUR_SHIFT) + 64'(HOUR_DIV) - 64'd1) / 64'(HOUR_DIV);

  localparam int unsigned MIN_PRE   = 2;
  localparam int unsigned MIN_DIV   = SECS_PER_MIN >> MIN_PRE;
  localparam int unsigned MIN_SHIFT = 14;
  localparam longint unsigned MIN_RECIP =
    ((64'd1 << MIN_SHIFT) + 64'(MIN_DIV) - 64'd1) / 64'(MIN_DIV);

  localparam int unsigned WD_SHIFT = 19;
  localparam longint unsigned WD_RECIP =
    ((64'd1 << WD_SHIFT) + 64'(DAYS_PER_WEEK) - 64'd1) / 64'(DAYS_PER_WEEK);

  localparam int unsigned B_SHIFT = 42;
  localparam longint unsigned B_RECIP =
    ((64'd1 << B_SHIFT) + 64'(DAYS_PER_400Y) - 64'd1) / 64'(DAYS_PER_400Y);

  localparam int unsigned D_SHIFT = 31;
  localparam longint unsigned D_RECIP =
    ((64'd1 << D_SHIFT) + 64'(DAYS_PER_4Y) - 64'd1) / 64'(DAYS_PER_4Y);

  localparam int unsigned MON_SHIFT = 19;
  localparam longint unsigned MON_RECIP =
    ((64'd1 << MON_SHIFT) + 64'(MONTH_SPAN) - 64'd1) / 64'(MONTH_SPAN);

  localparam int unsigned MDAY_DIV   = 5;
  localparam int unsigned MDAY_SHIFT = 14;
  localparam longint unsigned MDAY_RECIP =
    ((64'd1 << MDAY_SHIFT) + 64'(MDAY_DIV) - 64'd1) / 64'(MDAY_DIV);

endpackage

[rtl/usd_req_if.sv]
// ----------------------------------------------------------------------------
// usd_req_if
// Request channel: one epoch timestamp per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface usd_req_if;
  import usd_pkg::*;

  logic   valid;
  logic   ready;
  epoch_t epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

[rtl/usd_res_if.sv]
// ----------------------------------------------------------------------------
// usd_res_if
// Result channel: time of day, calendar date and weekday, valid/ready.
// ----------------------------------------------------------------------------
interface usd_res_if;
  import usd_pkg::*;

  logic   valid;
  logic   ready;
  sec_t   second_of_minute;
  min_t   minute_of_hour;
  hour_t  hour_of_day;
  mday_t  day_of_month;
  month_t month_of_year;
  year_t  years_since_1970;
  wday_t  weekday;

  modport source (
    output valid, output second_of_minute, output minute_of_hour,
    output hour_of_day, output day_of_month, output month_of_year,
    output years_since_1970, output weekday, input ready
  );
  modport sink (
    input valid, input second_of_minute, input minute_of_hour,
    input hour_of_day, input day_of_month, input month_of_year,
    input years_since_1970, input weekday, output ready
  );
endinterface

[rtl/usd_date_pipe.sv]
// ----------------------------------------------------------------------------
// usd_date_pipe
// Day count to Gregorian day, month and year via Julian Day Number inversion.
// ----------------------------------------------------------------------------
module usd_date_pipe (
  input  logic                           clk_i,
  input  logic [usd_pkg::PIPE_DEPTH:2]   en_i,
  input  usd_pkg::days_t                 days_i,
  output usd_pkg::mday_t                 day_of_month_o,
  output usd_pkg::month_t                month_of_year_o,
  output usd_pkg::year_t                 years_since_1970_o
);
  import usd_pkg::*;

  // stage 2: a = jdn + shift, b = (4a + 3) / 146097
  logic [21:0] a_d;
  logic [23:0] a4;
  logic [48:0] b_prod;
  logic [21:0] a_q2;
  logic [6:0]  b_q2;

  assign a_d    = 22'(days_i) + 22'(JDN_BASE);
  assign a4     = {a_d, 2'b11};
  assign b_prod = 49'(a4) * 49'(B_RECIP);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      a_q2 <= a_d;
      b_q2 <= b_prod[B_SHIFT +: 7];
    end
  end

  // stage 3: c = a - 146097 * b / 4
  logic [23:0] cb_prod;
  logic [21:0] c_full;
  logic [17:0] c_q3;
  logic [6:0]  b_q3;

  assign cb_prod = 24'(b_q2) * 24'(DAYS_PER_400Y);
  assign c_full  = a_q2 - cb_prod[23:2];

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      c_q3 <= c_full[17:0];
      b_q3 <= b_q2;
    end
  end

  // stage 4: d = (4c + 3) / 1461
  logic [19:0] c4;
  logic [40:0] d_prod;
  logic [17:0] c_q4;
  logic [8:0]  d_q4;
  logic [6:0]  b_q4;

  assign c4     = {c_q3, 2'b11};
  assign d_prod = 41'(c4) * 41'(D_RECIP);

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      c_q4 <= c_q3;
      d_q4 <= d_prod[D_SHIFT +: 9];
      b_q4 <= b_q3;
    end
  end

  // stage 5: e = c - 1461 * d / 4
  logic [19:0] ed_prod;
  logic [17:0] e_full;
  logic [8:0]  e_q5;
  logic [8:0]  d_q5;
  logic [6:0]  b_q5;

  assign ed_prod = 20'(d_q4) * 20'(DAYS_PER_4Y);
  assign e_full  = c_q4 - ed_prod[19:2];

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      e_q5 <= e_full[8:0];
      d_q5 <= d_q4;
      b_q5 <= b_q4;
    end
  end

  // stage 6: m = (5e + 2) / 153
  logic [11:0] e5;
  logic [23:0] mm_prod;
  logic [8:0]  e_q6;
  logic [3:0]  mm_q6;
  logic [8:0]  d_q6;
  logic [6:0]  b_q6;

  assign e5      = 12'(e_q5) * 12'(MDAY_DIV) + 12'd2;
  assign mm_prod = 24'(e5) * 24'(MON_RECIP);

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      e_q6  <= e_q5;
      mm_q6 <= mm_prod[MON_SHIFT +: 4];
      d_q6  <= d_q5;
      b_q6  <= b_q5;
    end
  end

  // stage 7: 153m + 2 and 100b + d
  logic [11:0] t153_d;
  logic [13:0] ybase_d;
  logic [8:0]  e_q7;
  logic [3:0]  mm_q7;
  logic [11:0] t153_q7;
  logic [13:0] ybase_q7;

  assign t153_d  = 12'(mm_q6) * 12'(MONTH_SPAN) + 12'd2;
  assign ybase_d = 14'(b_q6) * 14'(YEARS_PER_CENT) + 14'(d_q6);

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      e_q7     <= e_q6;
      mm_q7    <= mm_q6;
      t153_q7  <= t153_d;
      ybase_q7 <= ybase_d;
    end
  end

  // stage 8: day, month, year
  logic [23:0] md_prod;
  logic [8:0]  mday_full;
  logic        wrap;
  month_t      month_d;
  logic [13:0] year_full;
  mday_t       mday_q8;
  month_t      month_q8;
  year_t       year_q8;

  assign md_prod   = 24'(t153_q7) * 24'(MDAY_RECIP);
  assign mday_full = e_q7 - md_prod[MDAY_SHIFT +: 9] + 9'd1;
  assign wrap      = (mm_q7 >= 4'(MONTH_WRAP));
  assign month_d   = wrap ? (mm_q7 - 4'(MONTH_FOLD)) : (mm_q7 + 4'(MONTH_START));
  assign year_full = ybase_q7 + 14'(wrap) - 14'(YEAR_BIAS);

  always_ff @(posedge clk_i) begin
    if (en_i[8]) begin
      mday_q8  <= mday_full[4:0];
      month_q8 <= month_d;
      year_q8  <= year_full[7:0];
    end
  end

  assign day_of_month_o     = mday_q8;
  assign month_of_year_o    = month_q8;
  assign years_since_1970_o = year_q8;

endmodule

[rtl/unix_seconds_to_calendar_date_top.sv]
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar_date_top
// Converts a 32-bit count of seconds since 1970-01-01 into time of day,
// Gregorian date and weekday.
//
// Usage:
//   req_i carries one epoch_seconds value per request; res_o returns one
//   result per request, in order, with second, minute, hour, day, month,
//   years since 1970 and weekday (0 Monday .. 6 Sunday).
//   The pipeline has 8 register stages. Throughput is one request per
//   cycle while res_o.ready is high or an empty slot remains; each of the 8
//   register stages holds only constant multiplies and subtracts, so every
//   stage can take a new request each cycle when the stage after it has room.
//   Reset clears all stage valid bits; req_i.ready is high right after reset.
//   When the receiver holds res_o.ready low, the last stage keeps its result
//   and earlier stages keep filling empty slots; req_i.ready drops only once
//   every stage holds a request.
// ----------------------------------------------------------------------------
module unix_seconds_to_calendar_date_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  usd_req_if.sink   req_i,
  usd_res_if.source res_o
);
  import usd_pkg::*;

  // stage enables and valid bits
  logic [PIPE_DEPTH:1] en;
  logic [PIPE_DEPTH:1] v_in;
  logic [PIPE_DEPTH:1] v_d;
  logic [PIPE_DEPTH:1] v_q;

  assign en[PIPE_DEPTH] = !v_q[PIPE_DEPTH] || res_o.ready;
  for (genvar k = 1; k < PIPE_DEPTH; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  assign v_in = {v_q[PIPE_DEPTH-1:1], req_i.valid};
  assign v_d  = (en & v_in) | (~en & v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign req_i.ready = en[1];
  assign res_o.valid = v_q[PIPE_DEPTH];

  // stage 1: day count
  logic [50:0] day_prod;
  epoch_t      t_q1;
  days_t       days_q1;

  assign day_prod = 51'(req_i.epoch_seconds[31:DAY_PRE]) * 51'(DAY_RECIP);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      t_q1    <= req_i.epoch_seconds;
      days_q1 <= day_prod[DAY_SHIFT +: DAYS_W];
    end
  end

  // stage 2: second of day, weekday quotient
  logic [31:0] day_base;
  logic [31:0] sod_full;
  logic [15:0] wx;
  logic [32:0] wq_prod;
  logic [16:0] sod_q2;
  logic [15:0] wx_q2;
  logic [13:0] wq_q2;

  assign day_base = 32'(days_q1) * 32'(SECS_PER_DAY);
  assign sod_full = t_q1 - day_base;
  assign wx       = days_q1 + 16'(WEEKDAY_BIAS);
  assign wq_prod  = 33'(wx) * 33'(WD_RECIP);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      sod_q2 <= sod_full[16:0];
      wx_q2  <= wx;
      wq_q2  <= wq_prod[WD_SHIFT +: 14];
    end
  end

  // stage 3: hour, weekday
  logic [26:0] hr_prod;
  logic [15:0] wd_full;
  logic [16:0] sod_q3;
  hour_t       hour_q3;
  wday_t       wd_q3;

  assign hr_prod = 27'(sod_q2[16:HOUR_PRE]) * 27'(HOUR_RECIP);
  assign wd_full = wx_q2 - 16'(wq_q2) * 16'(DAYS_PER_WEEK);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      sod_q3  <= sod_q2;
      hour_q3 <= hr_prod[HOUR_SHIFT +: 5];
      wd_q3   <= wd_full[2:0];
    end
  end

  // stage 4: second of hour
  logic [16:0] hbase;
  logic [16:0] remh_full;
  logic [11:0] remh_q4;
  hour_t       hour_q4;
  wday_t       wd_q4;

  assign hbase     = 17'(hour_q3) * 17'(SECS_PER_HOUR);
  assign remh_full = sod_q3 - hbase;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      remh_q4 <= remh_full[11:0];
      hour_q4 <= hour_q3;
      wd_q4   <= wd_q3;
    end
  end

  // stage 5: minute
  logic [20:0] mn_prod;
  logic [11:0] remh_q5;
  min_t        min_q5;
  hour_t       hour_q5;
  wday_t       wd_q5;

  assign mn_prod = 21'(remh_q4[11:MIN_PRE]) * 21'(MIN_RECIP);

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      remh_q5 <= remh_q4;
      min_q5  <= mn_prod[MIN_SHIFT +: 6];
      hour_q5 <= hour_q4;
      wd_q5   <= wd_q4;
    end
  end

  // stage 6: second; stages 7 and 8 align with the date path
  logic [11:0] mbase;
  logic [11:0] sec_full;
  tod_t        tod_d6;
  tod_t        tod_q6;
  tod_t        tod_q7;
  tod_t        tod_q8;

  assign mbase    = 12'(min_q5) * 12'(SECS_PER_MIN);
  assign sec_full = remh_q5 - mbase;

  always_comb begin
    tod_d6.sec  = sec_full[5:0];
    tod_d6.min  = min_q5;
    tod_d6.hour = hour_q5;
    tod_d6.wday = wd_q5;
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      tod_q6 <= tod_d6;
    end
    if (en[7]) begin
      tod_q7 <= tod_q6;
    end
    if (en[8]) begin
      tod_q8 <= tod_q7;
    end
  end

  usd_date_pipe u_date_pipe (
    .clk_i              (clk_i),
    .en_i               (en[PIPE_DEPTH:2]),
    .days_i             (days_q1),
    .day_of_month_o     (res_o.day_of_month),
    .month_of_year_o    (res_o.month_of_year),
    .years_since_1970_o (res_o.years_since_1970)
  );

  assign res_o.second_of_minute = tod_q8.sec;
  assign res_o.minute_of_hour   = tod_q8.min;
  assign res_o.hour_of_day      = tod_q8.hour;
  assign res_o.weekday          = tod_q8.wday;

endmodule

[rtl/usd_checker.sv]
// ----------------------------------------------------------------------------
// usd_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "unix_seconds_to_calendar_date_top_defines.svh"

module usd_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input usd_pkg::sec_t   second_i,
  input usd_pkg::min_t   minute_i,
  input usd_pkg::hour_t  hour_i,
  input usd_pkg::mday_t  day_i,
  input usd_pkg::month_t month_i,
  input usd_pkg::year_t  year_i,
  input usd_pkg::wday_t  weekday_i
);
  import usd_pkg::*;

  logic [$bits(sec_t) + $bits(min_t) + $bits(hour_t) + $bits(mday_t)
         + $bits(month_t) + $bits(year_t) + $bits(wday_t) - 1:0] payload;
  logic stalled;
  logic fields_ok;

  assign payload   = {second_i, minute_i, hour_i, day_i, month_i, year_i, weekday_i};
  assign stalled   = out_valid_i && !out_ready_i;
  assign fields_ok = second_i < 6'd60 && minute_i < 6'd60 && hour_i < 5'd24
                     && day_i != 5'd0 && month_i != 4'd0 && month_i <= 4'd12
                     && weekday_i < 3'd7;

  `USD_ASSERT(a_out_valid_hold, stalled |=> out_valid_i, "result dropped while stalled")
  `USD_ASSERT_HOLD(a_out_payload_hold, out_valid_i, out_ready_i, payload, "result changed")
  `USD_ASSERT(a_in_refused, in_valid_i && !in_ready_i |-> stalled, "request refused early")
  `USD_ASSERT(a_field_range, out_valid_i |-> fields_ok, "result field out of range")

endmodule

bind unix_seconds_to_calendar_date_top usd_checker u_usd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .second_i    (res_o.second_of_minute),
  .minute_i    (res_o.minute_of_hour),
  .hour_i      (res_o.hour_of_day),
  .day_i       (res_o.day_of_month),
  .month_i     (res_o.month_of_year),
  .year_i      (res_o.years_since_1970),
  .weekday_i   (res_o.weekday)
);
